>>> hw/rtl/ile_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    // Field widths of the command and result words.
    localparam int MODE_W  = 3;
    localparam int POS_W   = 9;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 9;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [1:0]        kind_t;

    // Command codes.
    localparam mode_t MODE_READ   = 3'd0;
    localparam mode_t MODE_HEAD   = 3'd1;
    localparam mode_t MODE_TAIL   = 3'd2;
    localparam mode_t MODE_AT     = 3'd3;
    localparam mode_t MODE_DELETE = 3'd4;

    // Result status codes.
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // What the datapath must do for the captured command.
    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_READ   = 2'd1;
    localparam kind_t KIND_INSERT = 2'd2;
    localparam kind_t KIND_DELETE = 2'd3;

    // Value returned by a read past the end of the list.
    localparam logic [VAL_W-1:0] READ_MISS_VALUE = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic decide;
        logic shift;
        logic finish;
        logic load_result;
    } ile_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  busy;
    } ile_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ile_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ile_dp #(
    parameter int CAPACITY = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ile_pkg::ile_cmd_t              cmd,
    output ile_pkg::ile_stat_t                  stat,
    input  wire logic [ile_pkg::MODE_W-1:0]     mode,
    input  wire logic [ile_pkg::POS_W-1:0]      position,
    input  wire logic signed [ile_pkg::VAL_W-1:0] value,
    output logic signed [ile_pkg::VAL_W-1:0]    read_value,
    output logic [ile_pkg::STAT_W-1:0]          status,
    output logic [ile_pkg::CNT_W-1:0]           count
);
    import ile_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Element store, one write and one registered read per cycle.
    logic [VAL_W-1:0] mem [CAPACITY];

    // Captured command word.
    mode_t              mode_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]   val_reg;

    // List and shift control state.
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      slot_reg, slot_next;
    logic               ins_reg, ins_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    status_t            stat_reg, stat_next;
    logic [VAL_W-1:0]   mem_q_reg;

    // Result word.
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic [CNT_W-1:0]   res_count_reg, res_count_next;

    logic [CMPW-1:0]    pos_x;
    logic [CMPW-1:0]    cnt_x;
    logic               full;
    kind_t              kind;
    status_t            st;
    logic [CW-1:0]      slot;
    logic [CW-1:0]      dest;
    logic               re;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [VAL_W-1:0]   wdata;

    // Classify the captured command against the current count.
    always_comb
    begin
        pos_x = CMPW'(pos_reg);
        cnt_x = CMPW'(count_reg);
        full  = (count_reg == CW'(CAPACITY));
        kind  = KIND_NONE;
        st    = ST_DONE;
        slot  = '0;
        unique case (mode_reg)
            MODE_READ:
            begin
                if (pos_x < cnt_x)
                    kind = KIND_READ;
                else
                    st = ST_RANGE;
            end
            MODE_HEAD:
            begin
                if (full)
                    st = ST_FULL;
                else
                    kind = KIND_INSERT;
            end
            MODE_TAIL:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    kind = KIND_INSERT;
                    slot = count_reg;
                end
            end
            MODE_AT:
            begin
                if (pos_x > cnt_x)
                    st = ST_RANGE;
                else if (full)
                    st = ST_FULL;
                else
                begin
                    kind = KIND_INSERT;
                    slot = pos_x[CW-1:0];
                end
            end
            MODE_DELETE:
            begin
                if (pos_x >= cnt_x)
                    st = ST_RANGE;
                else
                begin
                    kind = KIND_DELETE;
                    slot = pos_x[CW-1:0];
                end
            end
            default:
            begin
                kind = KIND_NONE;
                st   = ST_DONE;
            end
        endcase
    end

    assign stat.kind = kind;
    assign stat.busy = (left_reg != '0) || pend_reg;

    // Insert moves each word one place up, delete one place down.
    assign dest = ins_reg ? (ptr_reg + CW'(1)) : (ptr_reg - CW'(1));

    // Memory port selection.
    always_comb
    begin
        re    = (cmd.decide && (kind == KIND_READ)) || (cmd.shift && (left_reg != '0));
        raddr = cmd.decide ? pos_x[AW-1:0] : ptr_reg[AW-1:0];
        we    = (cmd.shift && pend_reg) || (cmd.finish && ins_reg);
        waddr = cmd.finish ? slot_reg[AW-1:0] : pend_addr_reg;
        wdata = cmd.finish ? val_reg : mem_q_reg;
    end

    // Next state of the list and shift control.
    always_comb
    begin
        count_next     = count_reg;
        slot_next      = slot_reg;
        ins_next       = ins_reg;
        left_next      = left_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        stat_next      = stat_reg;
        if (cmd.decide)
        begin
            slot_next = slot;
            ins_next  = (kind == KIND_INSERT);
            stat_next = st;
            pend_next = 1'b0;
            if (kind == KIND_INSERT)
            begin
                left_next = count_reg - slot;
                ptr_next  = count_reg - CW'(1);
            end
            else if (kind == KIND_DELETE)
            begin
                left_next = count_reg - slot - CW'(1);
                ptr_next  = slot + CW'(1);
            end
            else
            begin
                left_next = '0;
            end
        end
        else if (cmd.shift)
        begin
            pend_next      = (left_reg != '0);
            pend_addr_next = dest[AW-1:0];
            if (left_reg != '0)
            begin
                left_next = left_reg - CW'(1);
                ptr_next  = ins_reg ? (ptr_reg - CW'(1)) : (ptr_reg + CW'(1));
            end
        end
        else if (cmd.finish)
        begin
            count_next = ins_reg ? (count_reg + CW'(1)) : (count_reg - CW'(1));
        end
    end

    // Result word assembly.
    always_comb
    begin
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        if (cmd.load_result)
        begin
            if (mode_reg != MODE_READ)
                res_value_next = '0;
            else if (stat_reg == ST_DONE)
                res_value_next = mem_q_reg;
            else
                res_value_next = READ_MISS_VALUE;
            res_status_next = stat_reg;
            res_count_next  = cnt_x[CNT_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            val_reg  <= value;
        end
        slot_reg       <= slot_next;
        ins_reg        <= ins_next;
        ptr_reg        <= ptr_next;
        pend_addr_reg  <= pend_addr_next;
        stat_reg       <= stat_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    // Element store.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            mem_q_reg <= mem[raddr];
    end

    assign read_value = res_value_reg;
    assign status     = res_status_reg;
    assign count      = res_count_reg;

    // The count only moves when an insert or delete completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(count_reg))
        else $error("count changed outside the finish step");

    // A shift never reads the word it is writing in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("read and write collide in the element store");

    // The list never holds more than the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && ins_reg |-> (count_reg < CW'(CAPACITY)))
        else $error("insert into a full list");

endmodule

`default_nettype wire

>>> hw/rtl/ile_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire ile_pkg::ile_stat_t stat,
    output ile_pkg::ile_cmd_t       cmd
);
    import ile_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Commands follow from the state and the input and output handshakes.
    always_comb
    begin
        cmd.load_item   = in_valid && in_ready;
        cmd.decide      = (state_reg == S_DECIDE);
        cmd.shift       = (state_reg == S_SHIFT);
        cmd.finish      = (state_reg == S_FINISH);
        cmd.load_result = (state_reg == S_DONE) && slot_free;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                unique case (stat.kind)
                    KIND_READ:   state_next = S_RDWAIT;
                    KIND_INSERT: state_next = S_SHIFT;
                    KIND_DELETE: state_next = S_SHIFT;
                    default:     state_next = S_DONE;
                endcase
            end
            S_RDWAIT:
                state_next = S_DONE;
            S_SHIFT:
            begin
                if (!stat.busy)
                    state_next = S_FINISH;
            end
            S_FINISH:
                state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new result never overwrites a word that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending word");

endmodule

`default_nettype wire

>>> hw/rtl/indexed_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Fields
// input     in_valid / in_ready    mode, position, value
// output    out_valid / out_ready  read_value, status, count
//
// A word is taken only while the sequencer is idle; the result sits in an
// output register, so the next word may be taken while it waits.
// A read passes through the decide, read-wait and done states, a
// status-only command through decide and done; an insert or delete passes
// through decide, shift, finish and done, and shift moves one element per
// cycle, set by the single read and single write port of the element store.
// Reset clears the count and control state; the store itself is not cleared.

module indexed_list_engine #(
    parameter int CAPACITY = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [ile_pkg::MODE_W-1:0]         mode,
    input  wire logic [ile_pkg::POS_W-1:0]          position,
    input  wire logic signed [ile_pkg::VAL_W-1:0]   value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [ile_pkg::VAL_W-1:0]        read_value,
    output logic [ile_pkg::STAT_W-1:0]              status,
    output logic [ile_pkg::CNT_W-1:0]               count
);
    import ile_pkg::*;

    ile_cmd_t  cmd;
    ile_stat_t stat;

    // Sequencer.
    ile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Element store, count and result register.
    ile_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .position   (position),
        .value      (value),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

endmodule

`default_nettype wire
